>>> rtl/multichannel_stuffed_frame_assembler_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stuffed frame assembler
// Concurrent assertion wrappers clocked on clk; one form is gated by rst.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_STUFFED_FRAME_ASSEMBLER_CORE_DEFINES_SVH
`define MULTICHANNEL_STUFFED_FRAME_ASSEMBLER_CORE_DEFINES_SVH

// Check a property at every edge outside reset.
`define MFA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define MFA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/mfa_pkg.sv
// ----------------------------------------------------------------------------
// Stuffed frame assembler package
// Field widths, mode codes, register indexes and framing constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfa_pkg;

  localparam int MODE_W    = 2;
  localparam int CHAN_W    = 2;
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 7;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam int CHANNELS_DEF    = 4;
  localparam int FRAME_BYTES_DEF = 64;

  localparam logic [MODE_W-1:0] MODE_DATA  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OPEN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLOSE = 2'd2;

  localparam logic REG_FLAG  = 1'b0;
  localparam logic REG_STUFF = 1'b1;

  localparam logic [BYTE_W-1:0] FLAG_RESET  = 8'd126;
  localparam logic [BYTE_W-1:0] STUFF_RESET = 8'd125;

  // Header bytes before the length check starts, position of the length byte,
  // and trailer bytes after the payload.
  localparam int HDR_BYTES   = 5;
  localparam int LEN_POS     = 4;
  localparam int TRAIL_BYTES = 2;

endpackage

>>> rtl/mfa_in_if.sv
// ----------------------------------------------------------------------------
// Input channel interface
// One received byte with its channel number and mode, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mfa_in_if;
  logic                       valid;
  logic                       ready;
  logic [mfa_pkg::MODE_W-1:0] mode;
  logic [mfa_pkg::CHAN_W-1:0] channel;
  logic [mfa_pkg::BYTE_W-1:0] data_in;

  modport source (output valid, output mode, output channel, output data_in, input ready);
  modport sink   (input valid, input mode, input channel, input data_in, output ready);
endinterface

>>> rtl/mfa_out_if.sv
// ----------------------------------------------------------------------------
// Output channel interface
// One emitted frame byte tagged with channel, frame length and last mark.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mfa_out_if;
  logic                       valid;
  logic                       ready;
  logic [mfa_pkg::CHAN_W-1:0] out_channel;
  logic [mfa_pkg::LEN_W-1:0]  frame_length;
  logic [mfa_pkg::BYTE_W-1:0] data_out;
  logic                       last;

  modport source (output valid, output out_channel, output frame_length, output data_out,
                  output last, input ready);
  modport sink   (input valid, input out_channel, input frame_length, input data_out,
                  input last, output ready);
endinterface

>>> rtl/multichannel_stuffed_frame_assembler_core.sv
// ----------------------------------------------------------------------------
// Multichannel stuffed frame assembler
// Collects byte-stuffed, length-framed frames per channel and emits them.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one word per received byte: mode (data, open, close), channel and
//            byte. Open clears the channel and makes it active, close makes it
//            inactive. Data bytes build the channel's frame in the frame memory.
//   out_ch : one word per stored byte of a completed frame, in arrival order,
//            tagged with channel and frame length; last marks the final byte.
//   APB    : flag_byte at 0x0, stuff_byte at 0x4; write only while idle.
// Timing:
//   For each input word the accept cycle reads the channel state memory, and
//   the next cycle modifies and writes it back with the frame byte.
//   A byte that completes a frame is followed by its n output words, each
//   with a frame memory read and then an output hold.
//   No input is taken while a frame is being emitted; a stalled receiver holds
//   the current output word and the block simply waits.
// Reset:
//   Channel state valid bits clear at once, so every channel reads as idle and
//   inactive in the first cycle after reset; registers return to defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multichannel_stuffed_frame_assembler_core #(
  parameter int CHANNELS    = mfa_pkg::CHANNELS_DEF,
  parameter int FRAME_BYTES = mfa_pkg::FRAME_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mfa_pkg::PADDR_W-1:0] paddr,
  input  logic [mfa_pkg::PDATA_W-1:0] pwdata,
  output logic [mfa_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  mfa_in_if.sink                      in_ch,
  mfa_out_if.source                   out_ch
);

  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MEM_DEPTH = CHANNELS * FRAME_BYTES;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int NEED_W    = 10;
  localparam int CNT_W     = mfa_pkg::LEN_W;
  localparam logic [CNT_W-1:0] FB_LIMIT = CNT_W'(FRAME_BYTES);

  typedef struct packed {
    logic                       active;
    logic                       pend;
    logic [CNT_W-1:0]           cnt;
    logic [CNT_W-1:0]           scnt;
    logic [mfa_pkg::BYTE_W-1:0] len;
  } chan_state_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROC,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_t;

  state_t state;

  logic [mfa_pkg::BYTE_W-1:0] flag_byte;
  logic [mfa_pkg::BYTE_W-1:0] stuff_byte;

  logic [mfa_pkg::MODE_W-1:0] mode_q;
  logic [CH_W-1:0]            ch_q;
  logic [mfa_pkg::BYTE_W-1:0] byte_q;

  chan_state_t                st_mem [CHANNELS];
  logic [CHANNELS-1:0]        st_vld;
  chan_state_t                st_q;
  logic                       st_vld_q;

  logic [mfa_pkg::BYTE_W-1:0] fmem [MEM_DEPTH];
  logic [mfa_pkg::BYTE_W-1:0] fm_q;

  logic [CNT_W-1:0]           emit_cnt;
  logic [CNT_W-1:0]           emit_k;

  logic                       in_acc;
  logic                       in_take;
  logic [CH_W-1:0]            in_idx;
  chan_state_t                cur;
  chan_state_t                st_next;
  logic                       st_we;
  logic                       fm_we;
  logic                       emit;
  logic [CNT_W-1:0]           cnt_n;
  logic [mfa_pkg::BYTE_W-1:0] len_n;
  logic [NEED_W-1:0]          need;
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              rd_addr;
  logic                       out_last;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_byte  <= mfa_pkg::FLAG_RESET;
      stuff_byte <= mfa_pkg::STUFF_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        mfa_pkg::REG_FLAG:  flag_byte  <= pwdata[mfa_pkg::BYTE_W-1:0];
        mfa_pkg::REG_STUFF: stuff_byte <= pwdata[mfa_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      mfa_pkg::REG_STUFF: prdata = {{(mfa_pkg::PDATA_W-mfa_pkg::BYTE_W){1'b0}}, stuff_byte};
      default:            prdata = {{(mfa_pkg::PDATA_W-mfa_pkg::BYTE_W){1'b0}}, flag_byte};
    endcase
  end

  // ---------------------------------------------------------------- input
  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_idx      = CH_W'(in_ch.channel);
  // Drop out-of-range channels and the unused mode right at the port.
  assign in_take     = in_acc && (int'(in_ch.channel) < CHANNELS) &&
                       (in_ch.mode == mfa_pkg::MODE_DATA || in_ch.mode == mfa_pkg::MODE_OPEN ||
                        in_ch.mode == mfa_pkg::MODE_CLOSE);

  // ---------------------------------------------------------------- state memory
  always_ff @(posedge clk) begin
    if (in_take) begin
      st_q     <= st_mem[in_idx];
      st_vld_q <= st_vld[in_idx];
    end
    if (state == S_PROC && st_we) begin
      st_mem[ch_q] <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld <= '0;
    end else if (state == S_PROC && st_we) begin
      st_vld[ch_q] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- modify
  always_comb begin
    cur     = st_vld_q ? st_q : '0;
    st_next = cur;
    st_we   = 1'b0;
    fm_we   = 1'b0;
    emit    = 1'b0;
    cnt_n   = cur.cnt;
    len_n   = cur.len;
    need    = '0;
    case (mode_q)
      mfa_pkg::MODE_OPEN: begin
        st_next.active = 1'b1;
        st_next.pend   = 1'b0;
        st_next.cnt    = '0;
        st_next.scnt   = '0;
        st_we          = 1'b1;
      end
      mfa_pkg::MODE_CLOSE: begin
        st_next.active = 1'b0;
        st_we          = 1'b1;
      end
      mfa_pkg::MODE_DATA: begin
        // Idle channels wait for the flag byte.
        if (cur.active && !(cur.cnt == '0 && byte_q != flag_byte)) begin
          if (byte_q == stuff_byte && !cur.pend) begin
            if (cur.cnt < FB_LIMIT) begin
              fm_we        = 1'b1;
              st_next.pend = 1'b1;
              st_next.cnt  = cur.cnt + 1'b1;
              st_next.scnt = cur.scnt + 1'b1;
              if (cur.cnt == CNT_W'(mfa_pkg::LEN_POS)) begin
                st_next.len = byte_q;
              end
              st_we = 1'b1;
            end
          end else begin
            st_we = 1'b1;
            if (cur.cnt < FB_LIMIT) begin
              fm_we = 1'b1;
              cnt_n = cur.cnt + 1'b1;
              if (cur.cnt == CNT_W'(mfa_pkg::LEN_POS)) begin
                len_n = byte_q;
              end
            end
            need = NEED_W'(mfa_pkg::HDR_BYTES + mfa_pkg::TRAIL_BYTES) + NEED_W'(len_n) +
                   NEED_W'(cur.scnt);
            st_next.pend = 1'b0;
            st_next.cnt  = cnt_n;
            st_next.len  = len_n;
            if (cnt_n >= CNT_W'(mfa_pkg::HDR_BYTES) &&
                (NEED_W'(cnt_n) >= need || cnt_n >= FB_LIMIT)) begin
              emit         = 1'b1;
              st_next.cnt  = '0;
              st_next.scnt = '0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- frame memory
  assign wr_addr = AW'(int'(ch_q) * FRAME_BYTES + int'(cur.cnt));
  assign rd_addr = AW'(int'(ch_q) * FRAME_BYTES + int'(emit_k));

  always_ff @(posedge clk) begin
    if (state == S_PROC && fm_we) begin
      fmem[wr_addr] <= byte_q;
    end
    if (state == S_EMIT_RD) begin
      fm_q <= fmem[rd_addr];
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign out_last = (emit_k == emit_cnt - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mode_q   <= mfa_pkg::MODE_DATA;
      ch_q     <= '0;
      byte_q   <= '0;
      emit_cnt <= '0;
      emit_k   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_take) begin
            mode_q <= in_ch.mode;
            ch_q   <= in_idx;
            byte_q <= in_ch.data_in;
            state  <= S_PROC;
          end
        end
        S_PROC: begin
          if (emit) begin
            emit_cnt <= cnt_n;
            emit_k   <= '0;
            state    <= S_EMIT_RD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          // Hold the word until the receiver takes it.
          if (out_ch.ready) begin
            if (out_last) begin
              state <= S_IDLE;
            end else begin
              emit_k <= emit_k + 1'b1;
              state  <= S_EMIT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = (state == S_EMIT_OUT);
  assign out_ch.out_channel  = mfa_pkg::CHAN_W'(ch_q);
  assign out_ch.frame_length = emit_cnt;
  assign out_ch.data_out     = fm_q;
  assign out_ch.last         = out_last;

endmodule

>>> rtl/mfa_checker.sv
// ----------------------------------------------------------------------------
// Stuffed frame assembler port checker
// Watches the channel ports of the top level over time; bound to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multichannel_stuffed_frame_assembler_core_defines.svh"

module mfa_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [mfa_pkg::CHAN_W-1:0] out_channel,
  input logic [mfa_pkg::LEN_W-1:0]  frame_length,
  input logic [mfa_pkg::BYTE_W-1:0] data_out,
  input logic                       last
);

  localparam logic [mfa_pkg::LEN_W-1:0] MIN_LEN = mfa_pkg::LEN_W'(mfa_pkg::HDR_BYTES);

  logic [mfa_pkg::CHAN_W+mfa_pkg::LEN_W+mfa_pkg::BYTE_W:0] out_word;
  logic                                                    out_stall;
  logic                                                    out_take;

  assign out_word  = {out_channel, frame_length, data_out, last};
  assign out_stall = out_valid && !out_ready;
  assign out_take  = out_valid && out_ready;

  // A stalled output word holds.
  `MFA_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_word), "stalled word changed")

  // No input is taken while a frame is being emitted.
  `MFA_ASSERT(a_no_overlap, !(in_ready && out_valid), "input ready during frame emission")

  // Every emitted frame holds at least the header.
  `MFA_ASSERT(a_min_len, out_valid |-> frame_length >= MIN_LEN, "frame shorter than header")

  // After the last word the block returns to accepting input.
  `MFA_ASSERT(a_last_ends, out_take && last |=> !out_valid && in_ready, "word after last")

  // Reset leaves the block idle with no output pending.
  `MFA_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid && in_ready, "block not idle after reset")

endmodule

bind multichannel_stuffed_frame_assembler_core mfa_checker u_mfa_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_channel  (out_ch.out_channel),
  .frame_length (out_ch.frame_length),
  .data_out     (out_ch.data_out),
  .last         (out_ch.last)
);

>>> verif/multichannel_stuffed_frame_assembler_core_test.sv
// ----------------------------------------------------------------------------
// Stuffed frame assembler testbench
// Drives mode/channel/byte words through the input channel and programs the
// flag and stuff registers over APB. An in-bench frame assembly model predicts
// every emitted word, and each output word is checked against it in order.
// A directed table is followed by random frames under several register
// settings and back-pressure mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multichannel_stuffed_frame_assembler_core_test;
  import mfa_pkg::*;

  localparam int CHANNELS      = CHANNELS_DEF;
  localparam int FRAME_BYTES   = FRAME_BYTES_DEF;
  localparam int PHASES        = 4;
  localparam int PHASE_WORDS   = 40;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 3000;
  localparam int DIRECTED_ROWS = 25;
  localparam int NO_CHECK      = -1;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] data;
    logic              last;
  } frame_word_t;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [CHAN_W-1:0] chan;
    logic [BYTE_W-1:0] data;
    int                reps;
    int                words_out;
  } stim_row_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  mfa_in_if  in_bus ();
  mfa_out_if out_bus ();

  multichannel_stuffed_frame_assembler_core #(
    .CHANNELS    (CHANNELS),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_bus),
    .out_ch  (out_bus)
  );

  // Frame assembly model state
  logic [BYTE_W-1:0] flag_val;
  logic [BYTE_W-1:0] stuff_val;
  bit                chan_open   [CHANNELS];
  bit                esc_pending [CHANNELS];
  int unsigned       fill        [CHANNELS];
  int unsigned       esc_total   [CHANNELS];
  logic [BYTE_W-1:0] frame_mem   [CHANNELS][FRAME_BYTES];
  frame_word_t       frame_words_due [$];

  int errors;
  int words_sent;
  int words_checked;
  int frames_checked;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_cycles;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{MODE_DATA,   2'd0, 8'h7E, 1,  0},         // channel not open yet
    '{MODE_OPEN,   2'd0, 8'h00, 1,  0},
    '{MODE_DATA,   2'd0, 8'h00, 1,  0},         // idle channel: not a flag
    '{MODE_DATA,   2'd0, 8'h7D, 1,  0},         // idle channel: stuff dropped too
    '{MODE_DATA,   2'd0, 8'h7E, 1,  0},
    '{MODE_DATA,   2'd0, 8'hFF, 3,  0},
    '{MODE_DATA,   2'd0, 8'h00, 1,  0},         // length byte 0
    '{MODE_DATA,   2'd0, 8'h7D, 1,  0},
    '{MODE_DATA,   2'd0, 8'h7D, 1,  0},         // escaped stuff stored plainly
    '{MODE_DATA,   2'd0, 8'h55, 1,  8},
    '{MODE_UNUSED, 2'd0, 8'h7E, 1,  0},
    '{MODE_CLOSE,  2'd0, 8'h00, 1,  0},
    '{MODE_DATA,   2'd0, 8'h7E, 1,  0},         // closed channel
    '{MODE_OPEN,   2'd1, 8'hFF, 1,  0},
    '{MODE_DATA,   2'd1, 8'h7E, 1,  0},
    '{MODE_DATA,   2'd1, 8'h01, 1,  0},
    '{MODE_CLOSE,  2'd1, 8'h00, 1,  0},
    '{MODE_OPEN,   2'd1, 8'h00, 1,  0},         // reopen drops the partial frame
    '{MODE_DATA,   2'd1, 8'h01, 1,  0},
    '{MODE_OPEN,   2'd3, 8'h00, 1,  0},
    '{MODE_DATA,   2'd3, 8'h7E, 1,  0},
    '{MODE_DATA,   2'd3, 8'h00, 3,  0},
    '{MODE_DATA,   2'd3, 8'hFF, 1,  NO_CHECK},  // length 255: only a full store ends it
    '{MODE_DATA,   2'd3, 8'h80, 58, 0},
    '{MODE_DATA,   2'd3, 8'h7D, 1,  0}          // stuff takes the last slot
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predict the words emitted for one accepted input word.
  function automatic int assemble_byte(input logic [MODE_W-1:0] mode,
                                       input logic [CHAN_W-1:0] ch,
                                       input logic [BYTE_W-1:0] b);
    int unsigned cnt;
    int unsigned need;
    int unsigned k;
    frame_word_t w;
    if (int'(ch) >= CHANNELS) return 0;
    if (mode == MODE_OPEN) begin
      esc_pending[ch] = 1'b0;
      fill[ch]        = 0;
      esc_total[ch]   = 0;
      chan_open[ch]   = 1'b1;
      return 0;
    end
    if (mode == MODE_CLOSE) begin
      chan_open[ch] = 1'b0;
      return 0;
    end
    if (mode != MODE_DATA || !chan_open[ch]) return 0;
    cnt = fill[ch];
    if (cnt == 0 && b != flag_val) return 0;
    if (b == stuff_val && !esc_pending[ch]) begin
      if (cnt >= FRAME_BYTES) return 0;
      esc_pending[ch]    = 1'b1;
      frame_mem[ch][cnt] = b;
      fill[ch]           = cnt + 1;
      esc_total[ch]      = esc_total[ch] + 1;
      return 0;
    end
    esc_pending[ch] = 1'b0;
    if (cnt < FRAME_BYTES) begin
      frame_mem[ch][cnt] = b;
      cnt                = cnt + 1;
      fill[ch]           = cnt;
    end
    if (cnt < HDR_BYTES) return 0;
    need = HDR_BYTES + frame_mem[ch][LEN_POS] + TRAIL_BYTES + esc_total[ch];
    if (cnt < need && cnt < FRAME_BYTES) return 0;
    for (k = 0; k < cnt; k++) begin
      w.chan = ch;
      w.len  = LEN_W'(cnt);
      w.data = frame_mem[ch][k];
      w.last = (k + 1 == cnt);
      frame_words_due.push_back(w);
    end
    esc_pending[ch] = 1'b0;
    fill[ch]        = 0;
    esc_total[ch]   = 0;
    return int'(cnt);
  endfunction

  // Present one word at a falling edge; return just after the accepting edge.
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [CHAN_W-1:0] ch,
                           input logic [BYTE_W-1:0] b, output int words);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.mode    <= mode;
    in_bus.channel <= ch;
    in_bus.data_in <= b;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    words      = assemble_byte(mode, ch, b);
    words_sent = words_sent + 1;
  endtask

  task automatic hold_off();
    @(negedge clk);
    in_bus.valid <= 1'b0;
  endtask

  task automatic wait_for_words();
    while (frame_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic idx, input logic [BYTE_W-1:0] wval,
                            output logic [PDATA_W-1:0] rval);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'(4 * int'(idx));
    pwdata  <= PDATA_W'(wval);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rval = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_register(input logic idx, input logic [BYTE_W-1:0] want);
    logic [PDATA_W-1:0] got;
    apb_access(1'b0, idx, '0, got);
    if (got !== PDATA_W'(want)) begin
      $display("%0t: register %0d readback: expected %h, got %h", $time, idx, want, got);
      errors = errors + 1;
    end
  endtask

  task automatic set_register(input logic idx, input logic [BYTE_W-1:0] val);
    logic [PDATA_W-1:0] unused_rd;
    apb_access(1'b1, idx, val, unused_rd);
    if (idx == REG_FLAG) flag_val = val;
    else stuff_val = val;
    check_register(idx, val);
  endtask

  task automatic send_noise();
    int junk;
    send_item(MODE_W'($urandom_range(3)), CHAN_W'($urandom_range(CHANNELS - 1)),
              BYTE_W'($urandom), junk);
  endtask

  // Mostly well-formed frames with random content; some noise and abandoned frames.
  task automatic send_random_frame(input logic [CHAN_W-1:0] ch);
    int words;
    int sent;
    bit abandon;
    logic [BYTE_W-1:0] b;
    words   = 0;
    sent    = 0;
    abandon = 1'b0;
    if (!chan_open[ch] || $urandom_range(7) == 0)
      send_item(MODE_OPEN, ch, BYTE_W'($urandom), words);
    send_item(MODE_DATA, ch, flag_val, words);
    while (words == 0 && sent < 90 && !abandon) begin
      if ($urandom_range(11) == 0) begin
        send_noise();
      end else begin
        if (fill[ch] == LEN_POS)
          b = ($urandom_range(9) == 0) ? BYTE_W'($urandom) : BYTE_W'($urandom_range(12));
        else if ($urandom_range(5) == 0)
          b = stuff_val;
        else
          b = BYTE_W'($urandom);
        send_item(MODE_DATA, ch, b, words);
      end
      sent    = sent + 1;
      abandon = ($urandom_range(59) == 0);
    end
  endtask

  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_words
    frame_word_t got;
    frame_word_t want;
    if (!rst && out_bus.valid && out_bus.ready) begin
      got = '{out_bus.out_channel, out_bus.frame_length, out_bus.data_out, out_bus.last};
      if (frame_words_due.size() == 0) begin
        $display("%0t: unexpected word: expected none, got ch=%0d len=%0d data=%h last=%b",
                 $time, got.chan, got.len, got.data, got.last);
        errors = errors + 1;
      end else begin
        want = frame_words_due.pop_front();
        if (got !== want) begin
          $display({"%0t: word mismatch: expected ch=%0d len=%0d data=%h last=%b, ",
                    "got ch=%0d len=%0d data=%h last=%b"},
                   $time, want.chan, want.len, want.data, want.last,
                   got.chan, got.len, got.data, got.last);
          errors = errors + 1;
        end
      end
      words_checked = words_checked + 1;
      if (got.last) frames_checked = frames_checked + 1;
    end
  end

  // End the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved in %0d cycles", $time, STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : run
    int words;
    int r;
    int rep;
    int phase;
    int phase_start;
    int frames;
    logic [BYTE_W-1:0] fval;
    logic [BYTE_W-1:0] sval;
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_bus.valid   = 1'b0;
    in_bus.mode    = MODE_DATA;
    in_bus.channel = '0;
    in_bus.data_in = '0;
    out_bus.ready  = 1'b0;
    errors         = 0;
    words_sent     = 0;
    words_checked  = 0;
    frames_checked = 0;
    stall_cycles   = 0;
    send_idle_pct  = 21;
    recv_idle_pct  = 69;
    flag_val       = FLAG_RESET;
    stuff_val      = STUFF_RESET;
    for (r = 0; r < CHANNELS; r++) begin
      chan_open[r]   = 1'b0;
      esc_pending[r] = 1'b0;
      fill[r]        = 0;
      esc_total[r]   = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    check_register(REG_FLAG, FLAG_RESET);
    check_register(REG_STUFF, STUFF_RESET);

    words = 0;
    for (r = 0; r < DIRECTED_ROWS; r++) begin
      for (rep = 0; rep < directed_rows[r].reps; rep++)
        send_item(directed_rows[r].mode, directed_rows[r].chan, directed_rows[r].data, words);
      if (directed_rows[r].words_out != NO_CHECK && words != directed_rows[r].words_out) begin
        $display("%0t: table row %0d: expected %0d emitted words, model gives %0d",
                 $time, r, directed_rows[r].words_out, words);
        errors = errors + 1;
      end
    end
    // Full store: this byte is not kept but flushes all 64 stored bytes.
    send_item(MODE_DATA, 2'd3, 8'h7D, words);
    if (words != FRAME_BYTES) begin
      $display("%0t: full store: expected %0d emitted words, model gives %0d",
               $time, FRAME_BYTES, words);
      errors = errors + 1;
    end

    for (phase = 0; phase < PHASES; phase++) begin
      hold_off();
      wait_for_words();
      case (phase)
        0: begin
          fval = 8'h00;
          sval = 8'hFF;
        end
        1: begin
          fval = 8'hFF;
          sval = 8'h00;
          send_idle_pct = 69;
          recv_idle_pct = 21;
        end
        2: begin
          fval = BYTE_W'($urandom);
          sval = BYTE_W'($urandom);
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        default: begin
          // flag and escape share one value
          fval = BYTE_W'($urandom);
          sval = fval;
        end
      endcase
      set_register(REG_FLAG, fval);
      set_register(REG_STUFF, sval);
      phase_start = words_sent;
      frames = 0;
      while (words_sent - phase_start < PHASE_WORDS) begin
        send_random_frame(CHAN_W'($urandom_range(CHANNELS - 1)));
        frames = frames + 1;
        if (frames == 3 || $urandom_range(11) == 0) begin
          // hold the sender until every emitted word has drained
          hold_off();
          while (frame_words_due.size() != 0) @(posedge clk);
        end
      end
    end

    hold_off();
    wait_for_words();
    $display("Sent %0d input words over a directed table and %0d random phases",
             words_sent, PHASES);
    $display("Checked %0d output words in %0d frames", words_checked, frames_checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> multichannel_stuffed_frame_assembler_core.f
+incdir+rtl
rtl/mfa_pkg.sv
rtl/mfa_in_if.sv
rtl/mfa_out_if.sv
rtl/multichannel_stuffed_frame_assembler_core.sv
rtl/mfa_checker.sv
verif/multichannel_stuffed_frame_assembler_core_test.sv
